>>> hw/rtl/wsd_pkg.sv
// ----------------------------------------------------------------------------
// WebSocket deframer package
// Shared types and constants for the WebSocket frame deframer.
// ----------------------------------------------------------------------------
package wsd_pkg;

  // Default width of the payload length counter.
  localparam int unsigned LENGTH_BITS_DEF = 64;

  // Second header byte: 7-bit length codes that announce an extended length.
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // Number of extended length bytes and mask key bytes.
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [2:0] MASK_BYTES  = 3'd4;

  // Continuation opcode, and the opcode bit that marks a control frame.
  localparam logic [3:0] OPC_CONTINUATION = 4'h0;
  localparam int unsigned OPC_CTRL_BIT    = 3;

  // Parser phase.
  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_MASK    = 3'd3,
    PH_PAYLOAD = 3'd4
  } wsd_phase_t;

  // One result beat.
  typedef struct packed {
    logic [7:0] payload_byte;
    logic       has_byte;
    logic [3:0] opcode;
    logic       is_control;
    logic       compressed;
    logic       frame_last;
    logic       message_last;
  } wsd_result_t;

endpackage

>>> hw/rtl/wsd_parser.sv
// ----------------------------------------------------------------------------
// WebSocket deframer header parser
// Holds the frame and message state, steps it by one stream byte when
// enabled, and presents the result beat that the byte causes, if any.
// ----------------------------------------------------------------------------
module wsd_parser #(
  parameter int unsigned LENGTH_BITS = wsd_pkg::LENGTH_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  logic [7:0]          byte_i,
  output logic                emit_o,
  output wsd_pkg::wsd_result_t result_o
);

  // State registers.
  wsd_pkg::wsd_phase_t    phase_r, phase_nxt;
  logic                   frame_fin_r, frame_fin_nxt;
  logic [3:0]             frame_opcode_r, frame_opcode_nxt;
  logic                   frame_rsv1_r, frame_rsv1_nxt;
  logic                   mask_present_r, mask_present_nxt;
  logic [3:0]             ext_left_r, ext_left_nxt;
  logic [31:0]            mask_key_r, mask_key_nxt;
  logic [2:0]             mask_left_r, mask_left_nxt;
  logic [1:0]             mask_pos_r, mask_pos_nxt;
  logic [LENGTH_BITS-1:0] remaining_r, remaining_nxt;
  logic [3:0]             msg_opcode_r, msg_opcode_nxt;
  logic                   msg_comp_r, msg_comp_nxt;

  // Shared decode.
  logic [6:0]             len7;
  logic                   len7_ext;
  logic [LENGTH_BITS-1:0] ext_shift;
  logic                   ext_last;
  logic                   mask_last;
  logic                   start;
  logic                   start_zero;
  logic                   is_ctl;
  logic [7:0]             key_byte;
  logic [3:0]             msg_opcode_upd;
  logic                   msg_comp_upd;
  logic                   flast;
  logic                   mlast;

  assign len7      = byte_i[6:0];
  assign len7_ext  = (len7 == wsd_pkg::LEN_EXT16) || (len7 == wsd_pkg::LEN_EXT64);
  assign ext_last  = (ext_left_r == 4'd1);
  assign mask_last = (mask_left_r == 3'd1);
  assign is_ctl    = frame_opcode_r[wsd_pkg::OPC_CTRL_BIT];

  // Extended length: shift in the next byte, saturating when it overflows.
  always_comb begin
    if (remaining_r[LENGTH_BITS-1 -: 8] != 8'd0) begin
      ext_shift = '1;
    end else begin
      ext_shift = {remaining_r[LENGTH_BITS-9:0], byte_i};
    end
  end

  // Payload start, and whether the frame turns out to be empty.
  always_comb begin
    start      = 1'b0;
    start_zero = 1'b0;
    unique case (phase_r)
      wsd_pkg::PH_HDR1: begin
        start      = !len7_ext && !byte_i[7];
        start_zero = (len7 == 7'd0);
      end
      wsd_pkg::PH_EXTLEN: begin
        start      = ext_last && !mask_present_r;
        start_zero = (ext_shift == '0);
      end
      wsd_pkg::PH_MASK: begin
        start      = mask_last;
        start_zero = (remaining_r == '0);
      end
      default: begin
        start      = 1'b0;
        start_zero = 1'b0;
      end
    endcase
  end

  // Next phase.
  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      wsd_pkg::PH_HDR0: begin
        phase_nxt = wsd_pkg::PH_HDR1;
      end
      wsd_pkg::PH_HDR1: begin
        if (len7_ext) begin
          phase_nxt = wsd_pkg::PH_EXTLEN;
        end else if (byte_i[7]) begin
          phase_nxt = wsd_pkg::PH_MASK;
        end else if (len7 == 7'd0) begin
          phase_nxt = wsd_pkg::PH_HDR0;
        end else begin
          phase_nxt = wsd_pkg::PH_PAYLOAD;
        end
      end
      wsd_pkg::PH_EXTLEN: begin
        if (!ext_last) begin
          phase_nxt = wsd_pkg::PH_EXTLEN;
        end else if (mask_present_r) begin
          phase_nxt = wsd_pkg::PH_MASK;
        end else if (ext_shift == '0) begin
          phase_nxt = wsd_pkg::PH_HDR0;
        end else begin
          phase_nxt = wsd_pkg::PH_PAYLOAD;
        end
      end
      wsd_pkg::PH_MASK: begin
        if (!mask_last) begin
          phase_nxt = wsd_pkg::PH_MASK;
        end else if (remaining_r == '0) begin
          phase_nxt = wsd_pkg::PH_HDR0;
        end else begin
          phase_nxt = wsd_pkg::PH_PAYLOAD;
        end
      end
      wsd_pkg::PH_PAYLOAD: begin
        if (remaining_r == LENGTH_BITS'(1)) begin
          phase_nxt = wsd_pkg::PH_HDR0;
        end else begin
          phase_nxt = wsd_pkg::PH_PAYLOAD;
        end
      end
      default: begin
        phase_nxt = wsd_pkg::PH_HDR0;
      end
    endcase
  end

  // Header fields, length, mask key and position.
  always_comb begin
    frame_fin_nxt    = frame_fin_r;
    frame_opcode_nxt = frame_opcode_r;
    frame_rsv1_nxt   = frame_rsv1_r;
    mask_present_nxt = mask_present_r;
    ext_left_nxt     = ext_left_r;
    mask_key_nxt     = mask_key_r;
    mask_left_nxt    = mask_left_r;
    mask_pos_nxt     = mask_pos_r;
    remaining_nxt    = remaining_r;
    unique case (phase_r)
      wsd_pkg::PH_HDR0: begin
        frame_fin_nxt    = byte_i[7];
        frame_rsv1_nxt   = byte_i[6];
        frame_opcode_nxt = byte_i[3:0];
      end
      wsd_pkg::PH_HDR1: begin
        mask_present_nxt = byte_i[7];
        mask_key_nxt     = '0;
        if (len7 == wsd_pkg::LEN_EXT16) begin
          ext_left_nxt  = wsd_pkg::EXT16_BYTES;
          remaining_nxt = '0;
        end else if (len7 == wsd_pkg::LEN_EXT64) begin
          ext_left_nxt  = wsd_pkg::EXT64_BYTES;
          remaining_nxt = '0;
        end else begin
          remaining_nxt = LENGTH_BITS'(len7);
          if (byte_i[7]) begin
            mask_left_nxt = wsd_pkg::MASK_BYTES;
          end
        end
      end
      wsd_pkg::PH_EXTLEN: begin
        remaining_nxt = ext_shift;
        ext_left_nxt  = ext_left_r - 4'd1;
        if (ext_last && mask_present_r) begin
          mask_left_nxt = wsd_pkg::MASK_BYTES;
        end
      end
      wsd_pkg::PH_MASK: begin
        mask_key_nxt  = {mask_key_r[23:0], byte_i};
        mask_left_nxt = mask_left_r - 3'd1;
      end
      wsd_pkg::PH_PAYLOAD: begin
        mask_pos_nxt  = mask_pos_r + 2'd1;
        remaining_nxt = remaining_r - LENGTH_BITS'(1);
      end
      default: begin
        mask_pos_nxt = mask_pos_r;
      end
    endcase
    if (start) begin
      mask_pos_nxt = 2'd0;
    end
  end

  // Message state as it stands once a data frame's payload begins.
  always_comb begin
    msg_opcode_upd = msg_opcode_r;
    msg_comp_upd   = msg_comp_r;
    if (start && !is_ctl && (frame_opcode_r != wsd_pkg::OPC_CONTINUATION)) begin
      msg_opcode_upd = frame_opcode_r;
      if (frame_rsv1_r) begin
        msg_comp_upd = 1'b1;
      end
    end
  end

  // Key byte for this payload position; the first key byte received is byte 0.
  assign key_byte = 8'(mask_key_r >> {~mask_pos_r, 3'b000});

  // Result beat.
  always_comb begin
    flast = (start && start_zero) ||
            ((phase_r == wsd_pkg::PH_PAYLOAD) && (remaining_r == LENGTH_BITS'(1)));
    emit_o = (start && start_zero) || (phase_r == wsd_pkg::PH_PAYLOAD);
    mlast  = flast && (is_ctl || frame_fin_r);

    result_o.has_byte     = (phase_r == wsd_pkg::PH_PAYLOAD);
    result_o.payload_byte = (phase_r == wsd_pkg::PH_PAYLOAD) ? (byte_i ^ key_byte) : 8'd0;
    result_o.opcode       = is_ctl ? frame_opcode_r : msg_opcode_upd;
    result_o.is_control   = is_ctl;
    result_o.compressed   = is_ctl ? 1'b0 : msg_comp_upd;
    result_o.frame_last   = flast;
    result_o.message_last = mlast;

    msg_opcode_nxt = msg_opcode_upd;
    msg_comp_nxt   = msg_comp_upd;
    if (emit_o && mlast && !is_ctl) begin
      msg_comp_nxt = 1'b0;
    end
  end

  // State update, one stream byte per enabled cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= wsd_pkg::PH_HDR0;
      frame_fin_r    <= 1'b0;
      frame_opcode_r <= 4'd0;
      frame_rsv1_r   <= 1'b0;
      mask_present_r <= 1'b0;
      ext_left_r     <= 4'd0;
      mask_key_r     <= 32'd0;
      mask_left_r    <= 3'd0;
      mask_pos_r     <= 2'd0;
      remaining_r    <= '0;
      msg_opcode_r   <= 4'd0;
      msg_comp_r     <= 1'b0;
    end else if (step_en) begin
      phase_r        <= phase_nxt;
      frame_fin_r    <= frame_fin_nxt;
      frame_opcode_r <= frame_opcode_nxt;
      frame_rsv1_r   <= frame_rsv1_nxt;
      mask_present_r <= mask_present_nxt;
      ext_left_r     <= ext_left_nxt;
      mask_key_r     <= mask_key_nxt;
      mask_left_r    <= mask_left_nxt;
      mask_pos_r     <= mask_pos_nxt;
      remaining_r    <= remaining_nxt;
      msg_opcode_r   <= msg_opcode_nxt;
      msg_comp_r     <= msg_comp_nxt;
    end
  end

endmodule

>>> hw/rtl/websocket_frame_deframer.sv
// ----------------------------------------------------------------------------
// WebSocket frame deframer
// Parses a WebSocket byte stream and emits unmasked payload bytes tagged
// with message opcode, control, compression and frame/message end flags.
// ----------------------------------------------------------------------------
// The block takes one stream byte per cycle and gives at most one result beat
// per byte, so it runs at one byte per clock with no gaps while out_stall is low.
// A byte first lands in an input register. Once the output register is free,
// the header parser steps its state and the unmasked result is written into
// the output register. Header bytes give no beat, except the last header
// byte of an empty frame, which gives one beat with has_byte low. Downstream
// stall holds the output register and, once the input register is also full,
// is passed back as in_stall.
module websocket_frame_deframer #(
  parameter int unsigned LENGTH_BITS = wsd_pkg::LENGTH_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_stream_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_payload_byte,
  output logic       out_has_byte,
  output logic [3:0] out_opcode,
  output logic       out_is_control,
  output logic       out_compressed,
  output logic       out_frame_last,
  output logic       out_message_last
);

  logic                in_valid_r;
  logic [7:0]          in_byte_r;
  logic                out_valid_r;
  wsd_pkg::wsd_result_t out_res_r;
  logic                out_free;
  logic                step_en;
  logic                emit;
  wsd_pkg::wsd_result_t res;

  // The output register can take a new beat when empty or being drained.
  assign out_free = !out_valid_r || !out_stall;
  assign step_en  = in_valid_r && out_free;
  assign in_stall = in_valid_r && !out_free;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte_r <= in_stream_byte;
    end
  end

  wsd_parser #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_en  (step_en),
    .byte_i   (in_byte_r),
    .emit_o   (emit),
    .result_o (res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= step_en && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en && emit) begin
      out_res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_payload_byte = out_res_r.payload_byte;
  assign out_has_byte     = out_res_r.has_byte;
  assign out_opcode       = out_res_r.opcode;
  assign out_is_control   = out_res_r.is_control;
  assign out_compressed   = out_res_r.compressed;
  assign out_frame_last   = out_res_r.frame_last;
  assign out_message_last = out_res_r.message_last;

endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// WebSocket frame deframer testbench
// Drives a WebSocket byte stream into the deframer and checks every result
// beat against a cycle-free model of the header parser and unmasking logic,
// or against a table row's own beat. A short table of hand-picked bytes comes
// first, then random frames of every length encoding, idling both channels at random.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LEN_W        = wsd_pkg::LENGTH_BITS_DEF;
  localparam int unsigned RANDOM_ITEMS = 900;
  localparam int unsigned QUIET_ITEMS  = 120;
  localparam int unsigned STALL_LIMIT  = 1000;
  localparam int unsigned DRAIN_CYCLES = 8;

  // Opcodes used in the stimulus.
  localparam logic [3:0] OPC_TEXT   = 4'h1;
  localparam logic [3:0] OPC_BINARY = 4'h2;
  localparam logic [3:0] OPC_PONG   = 4'hA;

  // Directed table: a row either relies on the model or carries its own beat.
  localparam logic PRED  = 1'b0;
  localparam logic TYPED = 1'b1;
  localparam wsd_pkg::wsd_result_t NO_BEAT = '0;

  typedef struct packed {
    logic [7:0]           stream_byte;
    logic                 typed;
    wsd_pkg::wsd_result_t beat;
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [23] = '{
    // Continuation straight after reset: the message opcode still reads zero.
    {{1'b0, 1'b0, 2'b00, wsd_pkg::OPC_CONTINUATION}, PRED, NO_BEAT},
    {{1'b0, 7'd1}, PRED, NO_BEAT},
    {8'hAB, TYPED, {8'hAB, 1'b1, wsd_pkg::OPC_CONTINUATION, 1'b0, 1'b0, 1'b1, 1'b0}},
    // Masked, compressed, empty text frame: the beat comes on the last key byte.
    {{1'b1, 1'b1, 2'b00, OPC_TEXT}, PRED, NO_BEAT},
    {{1'b1, 7'd0}, PRED, NO_BEAT},
    {8'hFF, PRED, NO_BEAT},
    {8'h00, PRED, NO_BEAT},
    {8'h5A, PRED, NO_BEAT},
    {8'hA5, TYPED, {8'h00, 1'b0, OPC_TEXT, 1'b0, 1'b1, 1'b1, 1'b1}},
    // Compressed binary start with a short 16-bit length, masked.
    {{1'b0, 1'b1, 2'b00, OPC_BINARY}, PRED, NO_BEAT},
    {{1'b1, wsd_pkg::LEN_EXT16}, PRED, NO_BEAT},
    {8'h00, PRED, NO_BEAT},
    {8'h01, PRED, NO_BEAT},
    {8'h12, PRED, NO_BEAT},
    {8'h34, PRED, NO_BEAT},
    {8'h56, PRED, NO_BEAT},
    {8'h78, PRED, NO_BEAT},
    {8'hFF, PRED, NO_BEAT},
    // Empty pong without FIN inside the fragmented message.
    {{1'b0, 1'b0, 2'b00, OPC_PONG}, PRED, NO_BEAT},
    {{1'b0, 7'd0}, TYPED, {8'h00, 1'b0, OPC_PONG, 1'b1, 1'b0, 1'b1, 1'b1}},
    // Final continuation closes the compressed binary message.
    {{1'b1, 1'b0, 2'b00, wsd_pkg::OPC_CONTINUATION}, PRED, NO_BEAT},
    {{1'b0, 7'd1}, PRED, NO_BEAT},
    {8'h00, PRED, NO_BEAT}
  };

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_stream_byte;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_payload_byte;
  logic       out_has_byte;
  logic [3:0] out_opcode;
  logic       out_is_control;
  logic       out_compressed;
  logic       out_frame_last;
  logic       out_message_last;

  websocket_frame_deframer i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_stream_byte   (in_stream_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_payload_byte (out_payload_byte),
    .out_has_byte     (out_has_byte),
    .out_opcode       (out_opcode),
    .out_is_control   (out_is_control),
    .out_compressed   (out_compressed),
    .out_frame_last   (out_frame_last),
    .out_message_last (out_message_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Parser state of the model, starting from its reset values.
  wsd_pkg::wsd_phase_t phase     = wsd_pkg::PH_HDR0;
  logic                f_fin     = 1'b0;
  logic                f_rsv1    = 1'b0;
  logic [3:0]          f_opc     = '0;
  logic                mask_on   = 1'b0;
  logic [3:0]          ext_left  = '0;
  logic [31:0]         key       = '0;
  logic [2:0]          key_left  = '0;
  logic [1:0]          key_pos   = '0;
  logic [LEN_W-1:0]    remaining = '0;
  logic [3:0]          msg_opc   = '0;
  logic                msg_comp  = 1'b0;

  wsd_pkg::wsd_result_t expected_beats [$];
  int unsigned errors      = 0;
  int unsigned beats_sent  = 0;
  int unsigned idle_odds   = 0;
  bit          quiet       = 1'b0;

  // Tags a beat with the frame and message context, closing the message if due.
  function automatic wsd_pkg::wsd_result_t frame_beat(logic [7:0] pay, logic has,
                                                      logic flast);
    wsd_pkg::wsd_result_t r;
    logic                 ctl;
    ctl            = f_opc[wsd_pkg::OPC_CTRL_BIT];
    r.payload_byte = pay;
    r.has_byte     = has;
    r.opcode       = ctl ? f_opc : msg_opc;
    r.is_control   = ctl;
    r.compressed   = ctl ? 1'b0 : msg_comp;
    r.frame_last   = flast;
    r.message_last = flast & (ctl | f_fin);
    if (r.message_last && !ctl) msg_comp = 1'b0;
    return r;
  endfunction

  // Header complete: latch the message context and handle empty frames.
  function automatic bit open_payload(output wsd_pkg::wsd_result_t r);
    key_pos = '0;
    r       = NO_BEAT;
    if (!f_opc[wsd_pkg::OPC_CTRL_BIT] && f_opc != wsd_pkg::OPC_CONTINUATION) begin
      msg_opc = f_opc;
      if (f_rsv1) msg_comp = 1'b1;
    end
    if (remaining == '0) begin
      phase = wsd_pkg::PH_HDR0;
      r     = frame_beat(8'h00, 1'b0, 1'b1);
      return 1'b1;
    end
    phase = wsd_pkg::PH_PAYLOAD;
    return 1'b0;
  endfunction

  function automatic bit length_done(output wsd_pkg::wsd_result_t r);
    r = NO_BEAT;
    if (mask_on) begin
      phase    = wsd_pkg::PH_MASK;
      key_left = wsd_pkg::MASK_BYTES;
      return 1'b0;
    end
    return open_payload(r);
  endfunction

  // Steps the parser by one stream byte; returns 1 when a beat results.
  function automatic bit deframe_step(input logic [7:0] b,
                                      output wsd_pkg::wsd_result_t r);
    logic [7:0] kb;
    r = NO_BEAT;
    case (phase)
      wsd_pkg::PH_HDR1: begin
        mask_on   = b[7];
        key       = '0;
        remaining = '0;
        if (b[6:0] == wsd_pkg::LEN_EXT16) begin
          ext_left = wsd_pkg::EXT16_BYTES;
          phase    = wsd_pkg::PH_EXTLEN;
          return 1'b0;
        end
        if (b[6:0] == wsd_pkg::LEN_EXT64) begin
          ext_left = wsd_pkg::EXT64_BYTES;
          phase    = wsd_pkg::PH_EXTLEN;
          return 1'b0;
        end
        remaining = LEN_W'(b[6:0]);
        return length_done(r);
      end
      wsd_pkg::PH_EXTLEN: begin
        // A length that would overflow the counter sticks at all ones.
        if ((remaining >> (LEN_W - 8)) != '0) remaining = '1;
        else remaining = {remaining[LEN_W-9:0], b};
        ext_left = ext_left - 4'd1;
        if (ext_left != '0) return 1'b0;
        return length_done(r);
      end
      wsd_pkg::PH_MASK: begin
        key      = {key[23:0], b};
        key_left = key_left - 3'd1;
        if (key_left != '0) return 1'b0;
        return open_payload(r);
      end
      wsd_pkg::PH_PAYLOAD: begin
        // The first key byte received sits in the top byte of the key.
        kb        = key[8 * (3 - int'(key_pos)) +: 8];
        key_pos   = key_pos + 2'd1;
        remaining = remaining - LEN_W'(1);
        if (remaining == '0) begin
          phase = wsd_pkg::PH_HDR0;
          r     = frame_beat(b ^ kb, 1'b1, 1'b1);
        end else begin
          r = frame_beat(b ^ kb, 1'b1, 1'b0);
        end
        return 1'b1;
      end
      default: begin
        f_fin  = b[7];
        f_rsv1 = b[6];
        f_opc  = b[3:0];
        phase  = wsd_pkg::PH_HDR1;
        return 1'b0;
      end
    endcase
  endfunction

  task automatic flag_mismatch(input string field, input int unsigned got,
                               input int unsigned want);
    $display("%0t ns: mismatch on %s: got %0h, expected %0h", $realtime, field, got, want);
    errors++;
  endtask

  // Offers one beat at the falling edge, after an optional gap, and waits
  // for it to be taken. Entered and left at a falling edge.
  task automatic drive_beat(input logic [7:0] b, input logic typed,
                            input wsd_pkg::wsd_result_t typed_beat);
    wsd_pkg::wsd_result_t r;
    bit                   got;
    quiet = (beats_sent + QUIET_ITEMS >= RANDOM_ITEMS + $size(DIR_ROWS));
    if (!quiet && idle_odds != 0 && $urandom_range(1, 8) <= idle_odds) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_valid       = 1'b1;
    in_stream_byte = b;
    do @(posedge clk); while (in_stall);
    beats_sent++;
    got = deframe_step(b, r);
    if (typed) expected_beats.push_back(typed_beat);
    else if (got) expected_beats.push_back(r);
    @(negedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b);
    drive_beat(b, PRED, NO_BEAT);
  endtask

  // One well-formed frame with random header fields, length and content.
  // Unknown opcodes and the reserved bits make up the odd share.
  task automatic random_frame();
    logic [3:0]  opc;
    logic [6:0]  len_code;
    logic [63:0] len;
    logic        masked;
    int unsigned kind;
    int unsigned sel;
    kind   = $urandom_range(0, 9);
    masked = 1'($urandom_range(0, 1));
    if (kind <= 2) opc = 4'(8 + $urandom_range(0, 7));
    else if (kind <= 4) opc = wsd_pkg::OPC_CONTINUATION;
    else opc = 4'($urandom_range(1, 7));
    sel = opc[wsd_pkg::OPC_CTRL_BIT] ? 0 : $urandom_range(0, 9);
    case (sel)
      6:       len = 64'($urandom_range(100, 125));
      7:       len = 64'($urandom_range(0, 20));
      8:       len = 64'($urandom_range(126, 300));
      9:       len = 64'($urandom_range(0, 20));
      default: len = 64'($urandom_range(0, 12));
    endcase
    len_code = (sel == 7 || sel == 8) ? wsd_pkg::LEN_EXT16 :
               (sel == 9) ? wsd_pkg::LEN_EXT64 : len[6:0];
    idle_odds = $urandom_range(0, 4);
    send_byte({1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), opc});
    send_byte({masked, len_code});
    if (len_code == wsd_pkg::LEN_EXT16) begin
      send_byte(len[15:8]);
      send_byte(len[7:0]);
    end else if (len_code == wsd_pkg::LEN_EXT64) begin
      for (int i = 7; i >= 0; i--) send_byte(len[8*i +: 8]);
    end
    if (masked) repeat (4) send_byte(8'($urandom_range(0, 255)));
    repeat (int'(len)) send_byte(8'($urandom_range(0, 255)));
  endtask

  // Stimulus and end of run.
  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_stream_byte = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n     = 1'b1;
    idle_odds = 2;
    foreach (DIR_ROWS[i]) drive_beat(DIR_ROWS[i].stream_byte, DIR_ROWS[i].typed,
                                     DIR_ROWS[i].beat);
    while (beats_sent < RANDOM_ITEMS + $size(DIR_ROWS)) random_frame();
    // Frame with an all-ones 64-bit length: the top bit is not checked and the
    // frame never ends within the run.
    send_byte({1'b1, 1'b0, 2'b00, OPC_BINARY});
    send_byte({1'b0, wsd_pkg::LEN_EXT64});
    repeat (8) send_byte(8'hFF);
    repeat (16) send_byte(8'($urandom_range(0, 255)));
    in_valid = 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("websocket_frame_deframer verification clean");
    end else begin
      $display("websocket_frame_deframer verification failed");
    end
    $finish;
  end

  // Result side stalls in random bursts, with calm stretches in between.
  initial begin
    int unsigned stall_odds;
    out_stall  = 1'b0;
    stall_odds = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 99) == 0) stall_odds = $urandom_range(0, 3);
      if (!quiet && stall_odds != 0 && $urandom_range(1, 16) <= stall_odds) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 14)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  // Each accepted result beat is checked against the oldest expectation.
  always @(posedge clk) begin : result_check
    wsd_pkg::wsd_result_t seen;
    wsd_pkg::wsd_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      seen = {out_payload_byte, out_has_byte, out_opcode, out_is_control,
              out_compressed, out_frame_last, out_message_last};
      if (expected_beats.size() == 0) begin
        flag_mismatch("beat with nothing expected", seen, 0);
      end else begin
        want = expected_beats.pop_front();
        if (seen.payload_byte !== want.payload_byte)
          flag_mismatch("payload_byte", seen.payload_byte, want.payload_byte);
        if (seen.has_byte !== want.has_byte)
          flag_mismatch("has_byte", seen.has_byte, want.has_byte);
        if (seen.opcode !== want.opcode)
          flag_mismatch("opcode", seen.opcode, want.opcode);
        if (seen.is_control !== want.is_control)
          flag_mismatch("is_control", seen.is_control, want.is_control);
        if (seen.compressed !== want.compressed)
          flag_mismatch("compressed", seen.compressed, want.compressed);
        if (seen.frame_last !== want.frame_last)
          flag_mismatch("frame_last", seen.frame_last, want.frame_last);
        if (seen.message_last !== want.message_last)
          flag_mismatch("message_last", seen.message_last, want.message_last);
      end
    end
  end

  // Watchdog: ends the run when neither channel moves a beat for too long.
  int unsigned still_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      still_cycles <= 0;
    end else if (still_cycles >= STALL_LIMIT) begin
      $display("websocket_frame_deframer verification failed");
      $finish;
    end else begin
      still_cycles <= still_cycles + 1;
    end
  end

endmodule
